FILE: hdl/utd_pkg.sv
// Shared types, constants and decode functions for the UTF-8 to UTF-32 decoder.
package utd_pkg;

    localparam int unsigned OCTET_W = 8;
    localparam int unsigned VALUE_W = 26;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned NEED_W  = 3;
    localparam int unsigned LEN_W   = 3;

    localparam logic [VALUE_W-1:0] SURR_LO = 26'h000D800;
    localparam logic [VALUE_W-1:0] SURR_HI = 26'h000E000;
    localparam logic [VALUE_W-1:0] CP_MAX  = 26'h010FFFF;

    typedef enum logic [2:0] {
        ST_INCOMPLETE = 3'd0,
        ST_CODEPOINT  = 3'd1,
        ST_NUL        = 3'd2,
        ST_ILLEGAL    = 3'd3,
        ST_QUERY      = 3'd4
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] partial_value;
        logic [NEED_W-1:0]  tails_pending;
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [CP_W-1:0]    code_point;
        logic [NEED_W-1:0]  bytes_needed;
    } t_result;

    // Sequence length from the top five bits of a byte; zero marks a tail byte.
    function automatic logic [LEN_W-1:0] len_class(input logic [4:0] top5);
        logic [LEN_W-1:0] len;
        len = 3'd0;
        priority if (top5[4] == 1'b0) begin
            len = 3'd1;
        end else if (top5[3] == 1'b0) begin
            len = 3'd0;
        end else if (top5[2] == 1'b0) begin
            len = 3'd2;
        end else if (top5[1] == 1'b0) begin
            len = 3'd3;
        end else if (top5[0] == 1'b0) begin
            len = 3'd4;
        end else begin
            len = 3'd5;
        end
        return len;
    endfunction

    // Payload bits kept from a lead byte of the given length.
    function automatic logic [OCTET_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
        logic [OCTET_W-1:0] mask;
        unique case (len)
            3'd1:    mask = 8'h7F;
            3'd2:    mask = 8'h1F;
            3'd3:    mask = 8'h0F;
            3'd4:    mask = 8'h07;
            3'd5:    mask = 8'h03;
            default: mask = 8'h00;
        endcase
        return mask;
    endfunction

endpackage

FILE: hdl/utd_step.sv
// Combinational decode of one byte against the running sequence state.
module utd_step (
    input  logic [7:0]      i_octet,
    input  logic            i_has_byte,
    input  utd_pkg::t_state i_state,
    output utd_pkg::t_state o_next_state,
    output utd_pkg::t_result o_result
);

    logic [utd_pkg::LEN_W-1:0]   len;
    logic [utd_pkg::VALUE_W-1:0] value;
    logic [utd_pkg::NEED_W-1:0]  tails_m1;
    logic                        finish;

    assign len      = utd_pkg::len_class(i_octet[7:3]);
    assign tails_m1 = i_state.tails_pending - 3'd1;

    always_comb begin
        o_next_state            = i_state;
        o_result.status         = utd_pkg::ST_ILLEGAL;
        o_result.code_point     = '0;
        o_result.bytes_needed   = i_state.tails_pending;
        value                   = '0;
        finish                  = 1'b0;

        if (!i_has_byte) begin
            o_result.status = utd_pkg::ST_QUERY;
        end else if (i_state.tails_pending == 3'd0) begin
            // A stray tail byte leaves everything as it was and reports illegal.
            if (len != 3'd0) begin
                value = {18'd0, i_octet & utd_pkg::lead_mask(len)};
                if (len > 3'd1) begin
                    o_next_state.partial_value = value;
                    o_next_state.tails_pending = len - 3'd1;
                    o_result.status            = utd_pkg::ST_INCOMPLETE;
                    o_result.bytes_needed      = len - 3'd1;
                end else begin
                    finish = 1'b1;
                end
            end
        end else begin
            // A lead byte inside a sequence is rejected without disturbing it.
            if (len == 3'd0) begin
                value = {i_state.partial_value[utd_pkg::VALUE_W-7:0], i_octet[5:0]};
                if (tails_m1 != 3'd0) begin
                    o_next_state.partial_value = value;
                    o_next_state.tails_pending = tails_m1;
                    o_result.status            = utd_pkg::ST_INCOMPLETE;
                    o_result.bytes_needed      = tails_m1;
                end else begin
                    finish = 1'b1;
                end
            end
        end

        if (finish) begin
            o_next_state          = '0;
            o_result.bytes_needed = '0;
            if (value == '0) begin
                o_result.status = utd_pkg::ST_NUL;
            end else if ((value >= utd_pkg::SURR_LO && value < utd_pkg::SURR_HI) ||
                         value > utd_pkg::CP_MAX) begin
                o_result.status = utd_pkg::ST_ILLEGAL;
            end else begin
                o_result.status     = utd_pkg::ST_CODEPOINT;
                o_result.code_point = value[utd_pkg::CP_W-1:0];
            end
        end
    end

endmodule

FILE: hdl/utf8_to_utf32_decoder_top.sv
// Top level of the UTF-8 to UTF-32 decoder: input register, decode step, result register.
//
//  Channel  | Direction | tdata (low bit up)                   | tuser
//  s_axis   | in        | octet[7:0]                           | has_byte
//  m_axis   | out       | code_point[20:0], bytes_needed[23:21]| status[2:0]
//
// One beat is accepted per cycle while m_axis does not stall, and one result
// beat leaves per input beat. A beat is registered in the input register and
// then decoded into the result register; the sequence state is updated in that
// same step, which sets the one-per-cycle rate.
// Reset clears the valid flags and the sequence state. A stall on m_axis holds
// both registers, and s_axis_tready falls only when both are full.
module utf8_to_utf32_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // octet[7:0]
    input  logic        s_axis_tuser,   // has_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // code_point[20:0], bytes_needed[23:21]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    logic                    r_in_valid;
    logic [7:0]              r_octet;
    logic                    r_has_byte;
    logic                    r_out_valid;
    utd_pkg::t_result        r_out;
    utd_pkg::t_state         r_state;

    utd_pkg::t_state         n_state;
    utd_pkg::t_result        n_out;
    logic                    out_free;
    logic                    step_fire;
    logic                    in_fire;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_fire     = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    utd_step u_step (
        .i_octet      (r_octet),
        .i_has_byte   (r_has_byte),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end
            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_octet    <= s_axis_tdata;
            r_has_byte <= s_axis_tuser;
        end
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.bytes_needed, r_out.code_point};
    assign m_axis_tuser  = r_out.status;

    a_tails_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.tails_pending <= 3'd4)
        else $error("tail count out of range");

    a_query_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && !r_has_byte |=> $stable(r_state))
        else $error("query beat changed the sequence state");

    a_incomplete_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && n_out.status == utd_pkg::ST_INCOMPLETE |=>
            r_state.tails_pending != 3'd0 &&
            r_out.bytes_needed == r_state.tails_pending)
        else $error("incomplete result without pending tails");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && (n_out.status == utd_pkg::ST_CODEPOINT ||
                      n_out.status == utd_pkg::ST_NUL) |=> r_state == '0)
        else $error("state not cleared after a finished code point");

    a_cp_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != utd_pkg::ST_CODEPOINT |-> r_out.code_point == '0)
        else $error("code point set on a non code point result");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the UTF-8 to UTF-32 decoder, with directed rows and random streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DIR_N        = 25;

    typedef struct packed {
        logic [7:0]       octet;
        logic             has_byte;
        logic             typed;      // expectation written in the row itself
        utd_pkg::t_result res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // octet[7:0]
    logic        s_axis_tuser = 1'b0;    // has_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // code_point[20:0], bytes_needed[23:21]
    logic [2:0]  m_axis_tuser;           // status[2:0]

    // Shadow of the decoder's sequence state.
    logic [utd_pkg::VALUE_W-1:0] acc_value;
    logic [utd_pkg::NEED_W-1:0]  acc_tails;

    utd_pkg::t_result expected_decodes[$];
    t_dir_row    dir_tab [DIR_N];
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned beat_cnt = 0;
    int unsigned n_cp = 0, n_nul = 0, n_bad = 0, n_query = 0, n_part = 0;
    int unsigned sink_left = 0;
    bit          calm = 1'b0;

    utf8_to_utf32_decoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Works out the result of one accepted beat and advances the shadow state.
    task automatic decode_octet(input logic [7:0] octet, input logic has_byte,
                                output utd_pkg::t_result res);
        logic [2:0]                  len;
        logic [7:0]                  keep;
        logic [utd_pkg::VALUE_W-1:0] value;
        bit                          done;
        res  = '{utd_pkg::ST_INCOMPLETE, '0, '0};
        done = 1'b0;
        value = '0;
        casez (octet[7:3])
            5'b0????: begin len = 3'd1; keep = 8'h7F; end
            5'b10???: begin len = 3'd0; keep = 8'h00; end
            5'b110??: begin len = 3'd2; keep = 8'h1F; end
            5'b1110?: begin len = 3'd3; keep = 8'h0F; end
            5'b11110: begin len = 3'd4; keep = 8'h07; end
            default:  begin len = 3'd5; keep = 8'h03; end
        endcase
        if (!has_byte) begin
            res = '{utd_pkg::ST_QUERY, '0, acc_tails};
        end else if (acc_tails == 0) begin
            if (len == 0) begin
                res = '{utd_pkg::ST_ILLEGAL, '0, acc_tails};
            end else if (len > 1) begin
                acc_value = utd_pkg::VALUE_W'(octet & keep);
                acc_tails = len - 3'd1;
                res = '{utd_pkg::ST_INCOMPLETE, '0, acc_tails};
            end else begin
                value = utd_pkg::VALUE_W'(octet & keep);
                done  = 1'b1;
            end
        end else if (len != 0) begin
            // A lead byte in the middle of a sequence leaves the state alone.
            res = '{utd_pkg::ST_ILLEGAL, '0, acc_tails};
        end else begin
            value = {acc_value[utd_pkg::VALUE_W-7:0], octet[5:0]};
            acc_tails = acc_tails - 3'd1;
            if (acc_tails != 0) begin
                acc_value = value;
                res = '{utd_pkg::ST_INCOMPLETE, '0, acc_tails};
            end else begin
                done = 1'b1;
            end
        end
        if (done) begin
            acc_value = '0;
            acc_tails = '0;
            if (value == 0) begin
                res = '{utd_pkg::ST_NUL, '0, '0};
            end else if ((value >= utd_pkg::SURR_LO && value < utd_pkg::SURR_HI) ||
                         value > utd_pkg::CP_MAX) begin
                res = '{utd_pkg::ST_ILLEGAL, '0, '0};
            end else begin
                res = '{utd_pkg::ST_CODEPOINT, value[utd_pkg::CP_W-1:0], '0};
            end
        end
    endtask

    // Offers one beat after a random gap and records its expectation once accepted.
    task automatic send_beat(input logic [7:0] octet, input logic has_byte,
                             input bit typed, input utd_pkg::t_result typed_res);
        int unsigned      gap;
        utd_pkg::t_result res;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= octet;
        s_axis_tuser  <= has_byte;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_octet(octet, has_byte, res);
        expected_decodes.push_back(typed ? typed_res : res);
        beat_cnt++;
    endtask

    task automatic send_octet(input logic [7:0] octet, input logic has_byte);
        send_beat(octet, has_byte, 1'b0, '{utd_pkg::ST_INCOMPLETE, '0, '0});
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %0s: got 0x%0h, expected 0x%0h (cycle %0d)",
                 what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // Result side: random back-pressure, with stretches of none while calm is set.
    always @(posedge i_clk) begin
        if (sink_left != 0) begin
            sink_left <= sink_left - 1;
        end else if (calm || $urandom_range(0, 1) == 1) begin
            m_axis_tready <= 1'b1;
            sink_left <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b0;
            sink_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        utd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_decodes.size() == 0) begin
                report_mismatch("unexpected beat", 32'({m_axis_tuser, m_axis_tdata}), 0);
            end else begin
                want = expected_decodes.pop_front();
                if (m_axis_tuser != want.status) begin
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                end
                if (m_axis_tdata[20:0] != want.code_point) begin
                    report_mismatch("code_point", 32'(m_axis_tdata[20:0]),
                                    32'(want.code_point));
                end
                if (m_axis_tdata[23:21] != want.bytes_needed) begin
                    report_mismatch("bytes_needed", 32'(m_axis_tdata[23:21]),
                                    32'(want.bytes_needed));
                end
                case (want.status)
                    utd_pkg::ST_CODEPOINT: n_cp++;
                    utd_pkg::ST_NUL:       n_nul++;
                    utd_pkg::ST_ILLEGAL:   n_bad++;
                    utd_pkg::ST_QUERY:     n_query++;
                    default:               n_part++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_decodes.size());
            $display("status: fail");
            $finish;
        end
    end

    // One random unit: mostly whole sequences, the rest truncations, noise and queries.
    task automatic send_random_unit();
        int unsigned kind;
        int unsigned len;
        int unsigned tails;
        logic [7:0]  lead;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            len = $urandom_range(1, 10);
            len = (len <= 2) ? 1 : (len <= 5) ? 2 : (len <= 7) ? 3 : (len <= 9) ? 4 : 5;
            case (len)
                1:       lead = 8'($urandom_range(0, 127));
                2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                4:       lead = 8'hF0 | 8'($urandom_range(0, 7));
                default: lead = 8'hF8 | 8'($urandom_range(0, 7));
            endcase
            // Truncate now and then so that the next lead interrupts the sequence.
            tails = len - 1;
            if (kind >= 65 && tails > 0) begin
                tails = $urandom_range(0, tails - 1);
            end
            send_octet(lead, 1'b1);
            repeat (tails) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_octet(8'($urandom), 1'b0);
                end
                send_octet(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
            end
        end else if (kind < 90) begin
            send_octet(8'($urandom), 1'b1);
        end else begin
            send_octet(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        int unsigned start_cnt;
        bit          drained;
        acc_value = '0;
        acc_tails = '0;
        dir_tab = '{
            '{8'hFF, 1'b0, 1'b1, '{utd_pkg::ST_QUERY,      21'h0,  3'd0}},
            '{8'h00, 1'b1, 1'b1, '{utd_pkg::ST_NUL,        21'h0,  3'd0}},
            '{8'h7F, 1'b1, 1'b1, '{utd_pkg::ST_CODEPOINT,  21'h7F, 3'd0}},
            '{8'h80, 1'b1, 1'b1, '{utd_pkg::ST_ILLEGAL,    21'h0,  3'd0}},
            '{8'hC3, 1'b1, 1'b1, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd1}},
            '{8'h41, 1'b1, 1'b1, '{utd_pkg::ST_ILLEGAL,    21'h0,  3'd1}},
            '{8'h00, 1'b0, 1'b1, '{utd_pkg::ST_QUERY,      21'h0,  3'd1}},
            '{8'hA9, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            // overlong NUL
            '{8'hC0, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'h80, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            // surrogate
            '{8'hED, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hA0, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'h80, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hEF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            // highest scalar value
            '{8'hF4, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'h8F, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            // five-byte lead, ends out of range
            '{8'hFF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}},
            '{8'hBF, 1'b1, 1'b0, '{utd_pkg::ST_INCOMPLETE, 21'h0,  3'd0}}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            send_beat(dir_tab[i].octet, dir_tab[i].has_byte, dir_tab[i].typed, dir_tab[i].res);
        end

        start_cnt = beat_cnt;
        drained = 1'b0;
        while (beat_cnt - start_cnt < RANDOM_ITEMS) begin
            calm = ((beat_cnt - start_cnt) / 100) % 4 == 1;
            if (!drained && beat_cnt - start_cnt >= RANDOM_ITEMS / 2) begin
                // Hold the sender off until every outstanding beat has come back.
                s_axis_tvalid <= 1'b0;
                while (expected_decodes.size() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            send_random_unit();
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d beats sent; %0d code points, %0d NULs, %0d illegal, %0d queries,",
                 beat_cnt, n_cp, n_nul, n_bad, n_query);
        $display("%0d partial sequences, with back-pressure on both sides and one full drain",
                 n_part);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/utd_pkg.sv
hdl/utd_step.sv
hdl/utf8_to_utf32_decoder_top.sv
verif/tb_top.sv
